>>> sv/conv2d_5x5_multi_filter_macros.svh
// Assertion macros for the convolution block checker.
`ifndef CONV2D_5X5_MULTI_FILTER_MACROS_SVH
`define CONV2D_5X5_MULTI_FILTER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define C2D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define C2D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/c2d_pkg.sv
// ---------------------------------------------------------------------------
// c2d_pkg: shared types and codes
// Item modes and the value, sum and position widths shared by front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package c2d_pkg;
    localparam logic [1:0] MODE_PIXEL    = 2'd0;
    localparam logic [1:0] MODE_WEIGHT   = 2'd1;
    localparam logic [1:0] MODE_BIAS     = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 21;
    localparam int POS_W   = 5;
endpackage
`default_nettype wire

>>> sv/c2d_front.sv
// ---------------------------------------------------------------------------
// c2d_front: line buffer, window and position tracking
// Accepts items, writes stores, shifts the window and queues window jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module c2d_front #(
    parameter int K  = 5,
    parameter int NF = 20,
    parameter int IMG = 28,
    parameter int WA = 9,
    parameter int PW = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               in_mode,
    input  wire logic [WA-1:0]            in_index,
    input  wire logic signed [15:0]       in_value,
    output logic                          w_we,
    output logic [WA-1:0]                 w_addr,
    output logic signed [15:0]            w_data,
    output logic                          b_we,
    output logic [$clog2(NF+1)-1:0]       b_addr,
    output logic signed [15:0]            b_data,
    // job queue toward back end
    output logic                          job_valid,
    input  wire logic                     job_ready,
    output logic signed [15:0]            job_win [K*K],
    output logic [PW-1:0]                 job_row,
    output logic [PW-1:0]                 job_col
);
    localparam int LBR = K - 1;
    localparam int CW  = $clog2(IMG);

    logic signed [15:0] lb_mem [LBR][IMG];
    logic signed [15:0] win_reg [K*K];
    logic [CW-1:0] row_reg, col_reg;
    logic full_reg;
    logic signed [15:0] q_win_reg [K*K];
    logic [PW-1:0] q_row_reg, q_col_reg;
    logic acc_pix, win_ok;

    // one-entry job slot: accept pixel only when it is empty or draining;
    // loads wait for an empty slot and an idle back end so stores stay fixed under a job
    assign in_ready  = (in_mode == c2d_pkg::MODE_PIXEL) ? (!full_reg || job_ready)
                                                        : (!full_reg && job_ready);
    assign acc_pix   = in_valid && in_ready && in_mode == c2d_pkg::MODE_PIXEL;
    assign win_ok    = (32'(row_reg) >= K - 1) && (32'(col_reg) >= K - 1);
    assign job_valid = full_reg;
    assign job_win   = q_win_reg;
    assign job_row   = q_row_reg;
    assign job_col   = q_col_reg;

    assign w_we   = in_valid && in_ready && in_mode == c2d_pkg::MODE_WEIGHT
                    && 32'(in_index) < NF * K * K;
    assign w_addr = in_index;
    assign w_data = in_value;
    assign b_we   = in_valid && in_ready && in_mode == c2d_pkg::MODE_BIAS
                    && 32'(in_index) < NF;
    assign b_addr = in_index[$clog2(NF+1)-1:0];
    assign b_data = in_value;

    always_ff @(posedge aclk) begin
        if (acc_pix) begin
            for (int k = 0; k < LBR; k++) begin
                lb_mem[k][col_reg] <= (k == LBR - 1) ? in_value : lb_mem[k+1][col_reg];
            end
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K - 1; j++) win_reg[i*K+j] <= win_reg[i*K+j+1];
                win_reg[i*K+K-1] <= (i == K - 1) ? in_value : lb_mem[i][col_reg];
            end
        end
        if (acc_pix && win_ok) begin
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K - 1; j++) q_win_reg[i*K+j] <= win_reg[i*K+j+1];
                q_win_reg[i*K+K-1] <= (i == K - 1) ? in_value : lb_mem[i][col_reg];
            end
            q_row_reg <= PW'(32'(row_reg) - (K - 1));
            q_col_reg <= PW'(32'(col_reg) - (K - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            full_reg <= 1'b0;
        end else begin
            if (acc_pix && win_ok) full_reg <= 1'b1;
            else if (job_ready)    full_reg <= 1'b0;
            if (acc_pix) begin
                if (32'(col_reg) == IMG - 1) begin
                    col_reg <= '0;
                    row_reg <= (32'(row_reg) == IMG - 1) ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/c2d_back.sv
// ---------------------------------------------------------------------------
// c2d_back: per-filter MAC sequencer
// Holds weight and bias memories; one multiply per cycle per window tap while in the MAC state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module c2d_back #(
    parameter int K  = 5,
    parameter int NF = 20,
    parameter int WA = 9,
    parameter int PW = 8,
    parameter int FW = 5
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     w_we,
    input  wire logic [WA-1:0]            w_addr,
    input  wire logic signed [15:0]       w_data,
    input  wire logic                     b_we,
    input  wire logic [$clog2(NF+1)-1:0]  b_addr,
    input  wire logic signed [15:0]       b_data,
    input  wire logic                     job_valid,
    output logic                          job_ready,
    input  wire logic signed [15:0]       job_win [K*K],
    input  wire logic [PW-1:0]            job_row,
    input  wire logic [PW-1:0]            job_col,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [FW-1:0]                 out_filter,
    output logic [PW-1:0]                 out_row,
    output logic [PW-1:0]                 out_col,
    output logic signed [20:0]            out_sum,
    output logic                          out_last
);
    localparam int KA = K * K;
    localparam int TW = $clog2(KA + 1);
    localparam int BA = $clog2(NF + 1);
    localparam int AW = 32 + $clog2(KA + 1);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_MAC = 2'd1, ST_OUT = 2'd2;

    logic signed [15:0] w_mem [NF*KA];
    logic signed [15:0] b_mem [NF];
    logic [1:0] st_reg;
    logic [TW-1:0] tap_reg;
    logic [FW-1:0] f_reg;
    logic [WA-1:0] ra_reg;
    logic signed [15:0] wq_reg, xq_reg, bq_reg;
    logic pv_reg;
    logic signed [31:0] prod_reg;
    logic pp_reg;
    logic signed [AW-1:0] acc_reg;
    logic [TW-1:0] cnt_reg;
    logic signed [15:0] win_reg [KA];
    logic [PW-1:0] row_reg, col_reg;
    logic signed [AW-1:0] shr;

    always_ff @(posedge aclk) begin
        if (w_we) w_mem[w_addr] <= w_data;
        if (b_we) b_mem[b_addr] <= b_data;
        wq_reg <= w_mem[ra_reg];
        bq_reg <= b_mem[f_reg[BA-1:0]];
        xq_reg <= win_reg[tap_reg[$clog2(KA)-1:0]];
        prod_reg <= wq_reg * xq_reg;
    end

    assign job_ready = st_reg == ST_IDLE;
    assign out_valid = st_reg == ST_OUT;
    assign shr = acc_reg >>> 15;
    assign out_sum = 21'(shr + AW'(bq_reg));
    assign out_filter = f_reg;
    assign out_row = row_reg;
    assign out_col = col_reg;
    assign out_last = 32'(f_reg) == NF - 1;

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            win_reg <= job_win;
            row_reg <= job_row;
            col_reg <= job_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            tap_reg <= '0;
            f_reg <= '0;
            ra_reg <= '0;
            pv_reg <= 1'b0;
            pp_reg <= 1'b0;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            pv_reg <= 1'b0;
            pp_reg <= pv_reg;
            if (pp_reg) begin
                acc_reg <= acc_reg + AW'(prod_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        st_reg <= ST_MAC;
                        f_reg <= '0;
                        ra_reg <= '0;
                        tap_reg <= '0;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                ST_MAC: begin
                    if (32'(tap_reg) < KA) begin
                        // read stage: issue address, data lands next cycle
                        pv_reg <= 1'b1;
                        tap_reg <= tap_reg + 1'b1;
                        ra_reg <= ra_reg + 1'b1;
                    end else if (32'(cnt_reg) == KA) begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_ready) begin
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        tap_reg <= '0;
                        if (32'(f_reg) == NF - 1) begin
                            st_reg <= ST_IDLE;
                        end else begin
                            f_reg <= f_reg + 1'b1;
                            st_reg <= ST_MAC;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/conv2d_5x5_multi_filter.sv
// ---------------------------------------------------------------------------
// conv2d_5x5_multi_filter: streaming valid 5x5 convolution, many filters
// Front end buffers lines and window; back end runs a shared MAC per filter.
// ---------------------------------------------------------------------------
// A window pixel fills the job slot; an idle back end takes the job and, per filter,
//   reads, multiplies and accumulates every tap, then holds the result until taken.
// The single multiplier steps one tap per cycle through each filter; the output handshake can hold it.
// Other pixels wait only while a job waits; loads wait for an idle back end.
// Reset (aresetn low, synchronous) clears position, queue and sequencer;
// weight, bias and line memories keep contents and are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_5x5_multi_filter #(
    parameter int KERNEL_SIZE  = 5,
    parameter int FILTER_COUNT = 20,
    parameter int IMAGE_SIZE   = 28
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [8:0] index, [24:9] value, rest zero
    input  wire logic [1:0]  s_tuser,  // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // [4:0] filter, [9:5] row, [14:10] col,
                                       // [35:15] sum, rest zero
    output logic             m_tlast   // last filter for this pixel
);
    localparam int WA = 9;
    localparam int PW = c2d_pkg::POS_W;
    localparam int FW = 5;
    localparam int KA = KERNEL_SIZE * KERNEL_SIZE;
    localparam int BA = $clog2(FILTER_COUNT + 1);

    logic w_we, b_we, job_valid, job_ready;
    logic [WA-1:0] w_addr;
    logic [BA-1:0] b_addr;
    logic signed [15:0] w_data, b_data;
    logic signed [15:0] job_win [KA];
    logic [PW-1:0] job_row, job_col, o_row, o_col;
    logic [FW-1:0] o_filter;
    logic signed [20:0] o_sum;
    logic o_last;

    c2d_front #(.K(KERNEL_SIZE), .NF(FILTER_COUNT), .IMG(IMAGE_SIZE), .WA(WA), .PW(PW))
    u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_mode(s_tuser),
        .in_index(s_tdata[8:0]), .in_value(s_tdata[24:9]),
        .w_we, .w_addr, .w_data, .b_we, .b_addr, .b_data,
        .job_valid, .job_ready, .job_win, .job_row, .job_col
    );

    c2d_back #(.K(KERNEL_SIZE), .NF(FILTER_COUNT), .WA(WA), .PW(PW), .FW(FW)) u_back (
        .aclk, .aresetn,
        .w_we, .w_addr, .w_data, .b_we, .b_addr, .b_data,
        .job_valid, .job_ready, .job_win, .job_row, .job_col,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_filter(o_filter),
        .out_row(o_row), .out_col(o_col), .out_sum(o_sum), .out_last(o_last)
    );

    // 36 bits of fields, zero filled to five bytes
    assign m_tdata = {4'd0, o_sum, o_col, o_row, o_filter};
    assign m_tlast = o_last;
endmodule
`default_nettype wire

>>> sv/conv2d_5x5_multi_filter_checker.sv
// ---------------------------------------------------------------------------
// conv2d_5x5_multi_filter_checker: port-level assertions
// Checks result ordering and handshake behavior on the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_5x5_multi_filter_macros.svh"
module conv2d_5x5_multi_filter_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    localparam logic [4:0] LAST_FILTER = 5'd19;

    logic        stall, step, last_ok;
    logic [4:0]  filt;
    logic [40:0] m_word;

    assign stall   = m_tvalid && !m_tready;
    assign step    = m_tvalid && m_tready && !m_tlast;
    assign filt    = m_tdata[4:0];
    assign last_ok = m_tlast == (filt == LAST_FILTER);
    assign m_word  = {m_tlast, m_tdata};

    `C2D_ASSERT_NXT(a_hold, aclk, aresetn, stall, m_tvalid && $stable(m_word), "result not held")
    `C2D_ASSERT_IMP(a_last, aclk, aresetn, m_tvalid, last_ok, "last flag misplaced")
    `C2D_ASSERT_NXT(a_next, aclk, aresetn, step, !m_tvalid || filt == $past(filt) + 5'd1, "no step")
    `C2D_ASSERT_IMP(a_known, aclk, aresetn, 1'b1, !$isunknown({s_tvalid, s_tready, m_tvalid}), "X")
endmodule
bind conv2d_5x5_multi_filter conv2d_5x5_multi_filter_checker u_checker (.*);
`default_nettype wire
